// File: rtl/core/calendar_clock_no_leap_defines.svh
// Assertion macros for the calendar clock checker.
// Used only by files that carry concurrent assertions; no other dependency.
`ifndef CALENDAR_CLOCK_NO_LEAP_DEFINES_SVH
`define CALENDAR_CLOCK_NO_LEAP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define CCNL_ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("calendar clock check failed");

// Check a property on every clock edge, reset included
`define CCNL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("calendar clock reset check failed");

`endif

// File: rtl/core/ccnl_pkg.sv
// Shared widths, constants, types and the month length table of the calendar clock.
// No dependencies; imported by every other file but the assertion macro header.
`timescale 1ns / 1ps

package ccnl_pkg;

  // Default parameter values
  localparam int YEAR_WIDTH_DEF     = 16;
  localparam int PRESCALE_WIDTH_DEF = 24;

  // Field widths
  localparam int TICKS_W       = 8;
  localparam int STEP_PERIOD_W = 24;
  localparam int MINUTE_STEP_W = 6;
  localparam int MINUTE_W      = 6;
  localparam int HOUR_W        = 5;
  localparam int DAY_W         = 5;
  localparam int MONTH_W       = 4;
  localparam int YEAR_OUT_W    = 16;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 24;

  // Reset values
  localparam logic [STEP_PERIOD_W-1:0] STEP_PERIOD_RST = 24'd1000;
  localparam logic [MINUTE_STEP_W-1:0] MINUTE_STEP_RST = 6'd5;
  localparam logic [DAY_W-1:0]         DAY_RST         = 5'd1;
  localparam logic [MONTH_W-1:0]       MONTH_RST       = 4'd1;
  localparam int                       YEAR_RST        = 2017;

  // Calendar limits
  localparam logic [MINUTE_W:0]  MINUTES_PER_HOUR = 7'd60;
  localparam logic [HOUR_W:0]    HOURS_PER_DAY    = 6'd24;
  localparam logic [MONTH_W:0]   MONTHS_PER_YEAR  = 5'd12;
  localparam logic [DAY_W-1:0]   DAYS_LONG        = 5'd31;
  localparam logic [DAY_W-1:0]   DAYS_SHORT       = 5'd30;
  localparam logic [DAY_W-1:0]   DAYS_FEB         = 5'd28;

  // Month codes with a length other than 31
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_PERIOD = 1'b0,
    REG_MINUTE_STEP = 1'b1
  } cfg_reg_t;

  // Calendar fields below the year
  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
  } cal_t;

  // Days in a month, no leap years; unknown codes count as long months
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    len = DAYS_LONG;
    if (m == MONTH_FEB) begin
      len = DAYS_FEB;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = DAYS_SHORT;
    end
    return len;
  endfunction

endpackage

// File: rtl/core/ccnl_if.sv
// Valid/ready channel interfaces for tick requests and calendar results.
// Depends on ccnl_pkg for field widths.
`timescale 1ns / 1ps

interface ccnl_in_if import ccnl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TICKS_W-1:0] elapsed_ticks;

  modport source (output valid, output elapsed_ticks, input ready);
  modport sink   (input valid, input elapsed_ticks, output ready);
endinterface

interface ccnl_out_if import ccnl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MINUTE_W-1:0]   minute;
  logic [HOUR_W-1:0]     hour;
  logic [DAY_W-1:0]      day;
  logic [MONTH_W-1:0]    month;
  logic [YEAR_OUT_W-1:0] year;
  logic                  stepped;

  modport source (output valid, output minute, output hour, output day, output month,
                  output year, output stepped, input ready);
  modport sink   (input valid, input minute, input hour, input day, input month,
                  input year, input stepped, output ready);
endinterface

// File: rtl/core/ccnl_step.sv
// Next-state logic of the calendar: saturating prescaler, step test and carry chain.
// Depends on ccnl_pkg for widths, limits and the month length table.
`timescale 1ns / 1ps

module ccnl_step import ccnl_pkg::*; #(
  parameter int YEAR_WIDTH     = YEAR_WIDTH_DEF,
  parameter int PRESCALE_WIDTH = PRESCALE_WIDTH_DEF
) (
  input  logic [PRESCALE_WIDTH-1:0] prescale,
  input  cal_t                      cal,
  input  logic [YEAR_WIDTH-1:0]     year,
  input  logic [TICKS_W-1:0]        ticks,
  input  logic [STEP_PERIOD_W-1:0]  step_period,
  input  logic [MINUTE_STEP_W-1:0]  minute_step,
  output logic [PRESCALE_WIDTH-1:0] prescale_next,
  output cal_t                      cal_next,
  output logic [YEAR_WIDTH-1:0]     year_next,
  output logic                      stepped
);

  localparam int CMP_W = (PRESCALE_WIDTH > STEP_PERIOD_W) ? PRESCALE_WIDTH : STEP_PERIOD_W;

  logic [PRESCALE_WIDTH:0]   pre_sum;
  logic [PRESCALE_WIDTH-1:0] pre_sat;
  logic [MINUTE_W:0]         min_sum;
  logic                      min_carry;
  logic [HOUR_W:0]           hour_sum;
  logic                      hour_carry;
  logic [DAY_W:0]            day_sum;
  logic                      day_carry;
  logic [MONTH_W:0]          month_sum;
  logic                      month_carry;

  // Add ticks and saturate at all ones
  assign pre_sum = {1'b0, prescale} + {{(PRESCALE_WIDTH + 1 - TICKS_W){1'b0}}, ticks};
  assign pre_sat = pre_sum[PRESCALE_WIDTH] ? '1 : pre_sum[PRESCALE_WIDTH-1:0];

  // Step when the period is reached; drop the remainder
  assign stepped       = CMP_W'(pre_sat) >= CMP_W'(step_period);
  assign prescale_next = stepped ? '0 : pre_sat;

  // Advance the minute; overflow clears rather than wraps
  assign min_sum   = {1'b0, cal.minute} + (stepped ? {1'b0, minute_step} : '0);
  assign min_carry = min_sum >= MINUTES_PER_HOUR;

  // Hour carry
  assign hour_sum   = {1'b0, cal.hour} + {{HOUR_W{1'b0}}, min_carry};
  assign hour_carry = hour_sum >= HOURS_PER_DAY;

  // Day carry against the month length
  assign day_sum   = {1'b0, cal.day} + {{DAY_W{1'b0}}, hour_carry};
  assign day_carry = day_sum > {1'b0, month_length(cal.month)};

  // Month carry
  assign month_sum   = {1'b0, cal.month} + {{MONTH_W{1'b0}}, day_carry};
  assign month_carry = month_sum > MONTHS_PER_YEAR;

  // Collect the new calendar
  always_comb begin
    cal_next.minute = min_carry   ? '0        : min_sum[MINUTE_W-1:0];
    cal_next.hour   = hour_carry  ? '0        : hour_sum[HOUR_W-1:0];
    cal_next.day    = day_carry   ? DAY_RST   : day_sum[DAY_W-1:0];
    cal_next.month  = month_carry ? MONTH_RST : month_sum[MONTH_W-1:0];
  end

  // Year wraps at its width
  assign year_next = year + YEAR_WIDTH'(month_carry);

endmodule

// File: rtl/core/calendar_clock_no_leap.sv
// Calendar clock with a tick prescaler: one result per tick request.
// Requests pass the input register, then the result register; ccnl_step lies between them.
// Throughput: one request per cycle unless results stall; prescaler and carry chain are one pass.
// A stalled result holds its register while the next request waits in the input register.
// Reset (synchronous, active high) empties both stages and loads 00:00, day 1, month 1, 2017.
`timescale 1ns / 1ps

module calendar_clock_no_leap import ccnl_pkg::*; #(
  parameter int YEAR_WIDTH     = YEAR_WIDTH_DEF,
  parameter int PRESCALE_WIDTH = PRESCALE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  ccnl_in_if.sink                in_ch,
  ccnl_out_if.source             out_ch,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [STEP_PERIOD_W-1:0]  step_period;
  logic [MINUTE_STEP_W-1:0]  minute_step;

  logic                      s1_valid;
  logic [TICKS_W-1:0]        s1_ticks;
  logic                      s1_move;
  logic                      out_free;

  logic [PRESCALE_WIDTH-1:0] prescale;
  cal_t                      cal;
  logic [YEAR_WIDTH-1:0]     year;

  logic [PRESCALE_WIDTH-1:0] prescale_next;
  cal_t                      cal_next;
  logic [YEAR_WIDTH-1:0]     year_next;
  logic                      stepped_next;

  logic                      out_valid;
  cal_t                      out_cal;
  logic [YEAR_WIDTH-1:0]     out_year;
  logic                      out_stepped;

  // Handshake: move a request on when the result register is free or being taken
  assign out_free    = !out_valid || out_ch.ready;
  assign s1_move     = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= STEP_PERIOD_RST;
      minute_step <= MINUTE_STEP_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_PERIOD: step_period <= cfg_data[STEP_PERIOD_W-1:0];
        REG_MINUTE_STEP: minute_step <= cfg_data[MINUTE_STEP_W-1:0];
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_ticks <= in_ch.elapsed_ticks;
    end
  end

  // Calendar update
  ccnl_step #(
    .YEAR_WIDTH     (YEAR_WIDTH),
    .PRESCALE_WIDTH (PRESCALE_WIDTH)
  ) u_step (
    .prescale      (prescale),
    .cal           (cal),
    .year          (year),
    .ticks         (s1_ticks),
    .step_period   (step_period),
    .minute_step   (minute_step),
    .prescale_next (prescale_next),
    .cal_next      (cal_next),
    .year_next     (year_next),
    .stepped       (stepped_next)
  );

  // Calendar state advances as each request passes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale   <= '0;
      cal.minute <= '0;
      cal.hour   <= '0;
      cal.day    <= DAY_RST;
      cal.month  <= MONTH_RST;
      year       <= YEAR_WIDTH'(YEAR_RST);
    end else if (s1_move) begin
      prescale <= prescale_next;
      cal      <= cal_next;
      year     <= year_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_cal     <= cal_next;
      out_year    <= year_next;
      out_stepped <= stepped_next;
    end
  end

  // Drive the result channel
  assign out_ch.valid   = out_valid;
  assign out_ch.minute  = out_cal.minute;
  assign out_ch.hour    = out_cal.hour;
  assign out_ch.day     = out_cal.day;
  assign out_ch.month   = out_cal.month;
  assign out_ch.year    = YEAR_OUT_W'(out_year);
  assign out_ch.stepped = out_stepped;

endmodule

// File: rtl/core/ccnl_checker.sv
// Port-level checks of the calendar clock, bound to the top level.
// Depends on ccnl_pkg and the assertion macros in calendar_clock_no_leap_defines.svh.
`timescale 1ns / 1ps
`include "calendar_clock_no_leap_defines.svh"

module ccnl_checker import ccnl_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [MINUTE_W-1:0]   minute,
  input logic [HOUR_W-1:0]     hour,
  input logic [DAY_W-1:0]      day,
  input logic [MONTH_W-1:0]    month,
  input logic [YEAR_OUT_W-1:0] year,
  input logic                  stepped
);

  // A result shown is always a legal calendar date and time
  `CCNL_ASSERT_RUN(a_date_legal, clk, rst, out_valid |-> (minute < 6'd60) && (hour < 5'd24) && (day != 5'd0) && (day <= month_length(month)) && (month != 4'd0) && (month <= 4'd12))

  // A stalled result holds until taken
  `CCNL_ASSERT_RUN(a_result_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(minute) && $stable(hour) && $stable(day) && $stable(month) && $stable(year) && $stable(stepped))

  // Reset leaves no result pending
  `CCNL_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid)

endmodule

bind calendar_clock_no_leap ccnl_checker u_ccnl_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .minute    (out_ch.minute),
  .hour      (out_ch.hour),
  .day       (out_ch.day),
  .month     (out_ch.month),
  .year      (out_ch.year),
  .stepped   (out_ch.stepped)
);

// File: sim/tb.sv
// Self-checking bench for calendar_clock_no_leap: tick requests in, calendar readings out.
// Holds its own calendar predictor and compares every reading field by field.
// Depends on ccnl_pkg, ccnl_in_if / ccnl_out_if and the calendar_clock_no_leap RTL.
`timescale 1ns / 1ps

module tb;
  import ccnl_pkg::*;

  localparam int unsigned PRESC_MAX = (1 << PRESCALE_WIDTH_DEF) - 1;

  // One calendar reading as the block reports it
  typedef struct packed {
    logic [MINUTE_W-1:0]   minute;
    logic [HOUR_W-1:0]     hour;
    logic [DAY_W-1:0]      day;
    logic [MONTH_W-1:0]    month;
    logic [YEAR_OUT_W-1:0] year;
    logic                  stepped;
  } cal_reading_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ccnl_in_if  in_ch ();
  ccnl_out_if out_ch ();

  calendar_clock_no_leap u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted calendar state and register copies
  logic [PRESCALE_WIDTH_DEF-1:0] tick_acc;
  logic [STEP_PERIOD_W-1:0]      period_reg;
  logic [MINUTE_STEP_W-1:0]      mstep_reg;
  int unsigned                   cal_minute;
  int unsigned                   cal_hour;
  int unsigned                   cal_day;
  int unsigned                   cal_month;
  logic [YEAR_OUT_W-1:0]         cal_year;

  cal_reading_t calendar_q[$];
  int unsigned  fault_count;
  bit           steady;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side at random unless a steady stretch is running
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 15);
  end

  function automatic int unsigned days_in_month(input int unsigned m);
    case (m)
      MONTH_FEB:                               return DAYS_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return DAYS_SHORT;
      default:                                 return DAYS_LONG;
    endcase
  endfunction

  // Advance the predicted calendar by one tick request and return the reading
  function automatic cal_reading_t advance_calendar(input logic [TICKS_W-1:0] ticks);
    int unsigned  sum;
    cal_reading_t r;
    sum = tick_acc + ticks;
    if (sum > PRESC_MAX) sum = PRESC_MAX;
    tick_acc  = sum[PRESCALE_WIDTH_DEF-1:0];
    r.stepped = 1'b0;
    if (tick_acc >= period_reg) begin
      tick_acc    = '0;
      r.stepped   = 1'b1;
      cal_minute += mstep_reg;
    end
    // Run the carries: minutes clear rather than wrap
    if (cal_minute >= 60) begin
      cal_minute = 0;
      cal_hour++;
    end
    if (cal_hour >= 24) begin
      cal_hour = 0;
      cal_day++;
    end
    if (cal_day > days_in_month(cal_month)) begin
      cal_day = 1;
      cal_month++;
    end
    if (cal_month > 12) begin
      cal_month = 1;
      cal_year  = cal_year + 1'b1;
    end
    r.minute = cal_minute[MINUTE_W-1:0];
    r.hour   = cal_hour[HOUR_W-1:0];
    r.day    = cal_day[DAY_W-1:0];
    r.month  = cal_month[MONTH_W-1:0];
    r.year   = cal_year;
    return r;
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) note_fault($sformatf("%s differs: expected %0d, got %0d", name, want, got));
  endtask

  // Compare each accepted reading with the oldest prediction
  always @(posedge clk) begin
    cal_reading_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (calendar_q.size() == 0) begin
        note_fault($sformatf("reading with no request pending: %0d:%0d %0d/%0d/%0d",
                             out_ch.hour, out_ch.minute, out_ch.day, out_ch.month, out_ch.year));
      end else begin
        want = calendar_q.pop_front();
        check_field("minute", want.minute, out_ch.minute);
        check_field("hour", want.hour, out_ch.hour);
        check_field("day", want.day, out_ch.day);
        check_field("month", want.month, out_ch.month);
        check_field("year", want.year, out_ch.year);
        check_field("stepped", want.stepped, out_ch.stepped);
      end
    end
  end

  // Offer one tick request, idling first at random; returns at a falling edge with valid high
  task automatic send_ticks(input logic [TICKS_W-1:0] ticks);
    while (!steady && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.elapsed_ticks <= ticks;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    calendar_q.push_back(advance_calendar(ticks));
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted reading has arrived
  task automatic drain_calendar();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (calendar_q.size() != 0) @(negedge clk);
  endtask

  // Write both registers back to back; junk above the minute step field must be ignored
  task automatic set_rate(input logic [STEP_PERIOD_W-1:0] period,
                          input logic [MINUTE_STEP_W-1:0] mstep);
    logic [CFG_DATA_W-1:0] word;
    word                      = CFG_DATA_W'($urandom);
    word[MINUTE_STEP_W-1:0]   = mstep;
    cfg_write <= 1'b1;
    cfg_index <= REG_STEP_PERIOD;
    cfg_data  <= period;
    @(negedge clk);
    cfg_index <= REG_MINUTE_STEP;
    cfg_data  <= word;
    @(negedge clk);
    cfg_write  <= 1'b0;
    period_reg  = period;
    mstep_reg   = mstep;
    @(negedge clk);
  endtask

  function automatic logic [TICKS_W-1:0] pick_ticks();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return TICKS_W'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_PERIOD_W-1:0] pick_period();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return STEP_PERIOD_W'($urandom_range(200, 1000));
      default: return STEP_PERIOD_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [MINUTE_STEP_W-1:0] pick_mstep();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return MINUTE_STEP_W'(59);
      3:       return MINUTE_STEP_W'(1);
      default: return MINUTE_STEP_W'($urandom_range(0, 63));
    endcase
  endfunction

  // Reset rate: four full requests reach the 1000 tick period
  task automatic check_power_on_rate();
    send_ticks('0);
    repeat (4) send_ticks('1);
    drain_calendar();
  endtask

  // Zero period steps on every request; zero and oversized minute steps
  task automatic check_zero_period();
    set_rate('0, '0);
    send_ticks('0);
    send_ticks('0);
    drain_calendar();
    set_rate('0, '1);
    send_ticks('0);
    send_ticks(TICKS_W'(8'h55));
    send_ticks(TICKS_W'(8'hAA));
    drain_calendar();
  endtask

  // Build up a count under the largest period, then lower the period below it
  task automatic check_period_lowered();
    set_rate('1, MINUTE_STEP_W'(59));
    repeat (3) send_ticks(TICKS_W'(200));
    drain_calendar();
    set_rate(STEP_PERIOD_W'(300), MINUTE_STEP_W'(59));
    send_ticks('0);
    drain_calendar();
    // Minute step of 59 overflows on the first and third steps and clears to zero
    set_rate(STEP_PERIOD_W'(1), MINUTE_STEP_W'(59));
    repeat (3) send_ticks(TICKS_W'(1));
    drain_calendar();
  endtask

  // Random requests over a run of random rates
  task automatic check_mixed_rates();
    for (int phase = 0; phase < 13; phase++) begin
      set_rate(pick_period(), pick_mstep());
      steady = (phase == 3);
      for (int i = 0; i < 100; i++) begin
        // hold off mid-phase until everything has come back
        if (i == 50 && phase % 4 == 1) drain_calendar();
        send_ticks(pick_ticks());
      end
      drain_calendar();
    end
    steady = 1'b0;
  endtask

  // One hour per request for several weeks, so as to pass a month end
  task automatic check_month_ends();
    set_rate('0, MINUTE_STEP_W'(63));
    repeat (630) send_ticks(pick_ticks());
    drain_calendar();
  endtask

  initial begin
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.elapsed_ticks = '0;
    out_ch.ready        = 1'b0;
    cfg_write           = 1'b0;
    cfg_index           = REG_STEP_PERIOD;
    cfg_data            = '0;
    steady              = 1'b0;
    fault_count         = 0;
    tick_acc            = '0;
    period_reg          = STEP_PERIOD_RST;
    mstep_reg           = MINUTE_STEP_RST;
    cal_minute          = 0;
    cal_hour            = 0;
    cal_day             = DAY_RST;
    cal_month           = MONTH_RST;
    cal_year            = YEAR_OUT_W'(YEAR_RST);
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    check_power_on_rate();
    check_zero_period();
    check_period_lowered();
    check_mixed_rates();
    check_month_ends();

    repeat (10) @(negedge clk);
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ccnl_pkg.sv
rtl/core/ccnl_if.sv
rtl/core/ccnl_step.sv
rtl/core/calendar_clock_no_leap.sv
rtl/core/ccnl_checker.sv
sim/tb.sv
